[sv/mcst_pkg.sv]
// Shared constants, types and report packing for the contact slot tracker.
// No dependencies; the top level takes this package by wildcard import.
`timescale 1ns / 1ps

package mcst_pkg;

    localparam int SLOT_COUNT = 8;
    localparam int COORD_BITS = 16;
    localparam int ID_BITS    = 32;
    localparam int SLOT_BITS  = $clog2(SLOT_COUNT);
    localparam int CNT_BITS   = SLOT_BITS + 1;
    localparam int DELTA_BITS = COORD_BITS + 1;

    localparam int S_FID_LSB    = 0;
    localparam int S_DOWN_LSB   = S_FID_LSB + ID_BITS;
    localparam int S_X_LSB      = S_DOWN_LSB + 1;
    localparam int S_Y_LSB      = S_X_LSB + COORD_BITS;
    localparam int S_FIELDS_W   = S_Y_LSB + COORD_BITS;
    localparam int S_DATA_W     = ((S_FIELDS_W + 7) / 8) * 8;

    localparam int M_SLOT_LSB   = 0;
    localparam int M_STATUS_LSB = M_SLOT_LSB + SLOT_BITS;
    localparam int M_TOUCH_LSB  = M_STATUS_LSB + 2;
    localparam int M_PX_LSB     = M_TOUCH_LSB + ID_BITS;
    localparam int M_PY_LSB     = M_PX_LSB + COORD_BITS;
    localparam int M_DX_LSB     = M_PY_LSB + COORD_BITS;
    localparam int M_DY_LSB     = M_DX_LSB + DELTA_BITS;
    localparam int M_PHASE_LSB  = M_DY_LSB + DELTA_BITS;
    localparam int M_REL_LSB    = M_PHASE_LSB + 2;
    localparam int M_FIELDS_W   = M_REL_LSB + 1;
    localparam int M_DATA_W     = ((M_FIELDS_W + 7) / 8) * 8;

    localparam logic [1:0] REQ_EVENT = 2'd0;
    localparam logic [1:0] REQ_TICK  = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    localparam logic [1:0] KIND_EVENT = 2'd0;
    localparam logic [1:0] KIND_SLOT  = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    typedef enum logic [1:0] {
        PH_JUST = 2'd0,
        PH_HELD = 2'd1,
        PH_UP   = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        EV_MOVED    = 2'd0,
        EV_RELEASED = 2'd1,
        EV_CLAIMED  = 2'd2,
        EV_DROPPED  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_EVT_OUT,
        S_TICK,
        S_CLEAR_OUT
    } state_t;

    typedef struct packed {
        logic [ID_BITS-1:0]           finger;
        logic [ID_BITS-1:0]           touch;
        phase_t                       phase;
        logic signed [COORD_BITS-1:0] cur_x;
        logic signed [COORD_BITS-1:0] cur_y;
        logic signed [COORD_BITS-1:0] prev_x;
        logic signed [COORD_BITS-1:0] prev_y;
    } slot_t;

    localparam slot_t SLOT_RESET = '{
        finger: '0, touch: '0, phase: PH_UP,
        cur_x: '0, cur_y: '0, prev_x: '0, prev_y: '0
    };

    function automatic logic [M_DATA_W-1:0] make_report(
        input logic [SLOT_BITS-1:0] slot,
        input status_t              status,
        input slot_t                e
    );
        logic [M_DATA_W-1:0]   r;
        logic                  active;
        logic [DELTA_BITS-1:0] dx;
        logic [DELTA_BITS-1:0] dy;
        active = (e.phase != PH_UP);
        dx = active ? ({e.cur_x[COORD_BITS-1], e.cur_x} - {e.prev_x[COORD_BITS-1], e.prev_x})
                    : '0;
        dy = active ? ({e.cur_y[COORD_BITS-1], e.cur_y} - {e.prev_y[COORD_BITS-1], e.prev_y})
                    : '0;
        r = '0;
        r[M_SLOT_LSB +: SLOT_BITS]    = slot;
        r[M_STATUS_LSB +: 2]          = status;
        r[M_TOUCH_LSB +: ID_BITS]     = e.touch;
        r[M_PX_LSB +: COORD_BITS]     = e.cur_x;
        r[M_PY_LSB +: COORD_BITS]     = e.cur_y;
        r[M_DX_LSB +: DELTA_BITS]     = dx;
        r[M_DY_LSB +: DELTA_BITS]     = dy;
        r[M_PHASE_LSB +: 2]           = e.phase;
        r[M_REL_LSB]                  = !active && (e.finger != '0) && (e.touch != '0);
        return r;
    endfunction

    function automatic slot_t tick_update(input slot_t e);
        slot_t r;
        r = e;
        if (e.phase == PH_UP) begin
            r.finger = '0;
            r.touch  = '0;
        end else begin
            r.prev_x = e.cur_x;
            r.prev_y = e.cur_y;
            if (e.phase == PH_JUST) begin
                r.phase = PH_HELD;
            end
        end
        return r;
    endfunction

endpackage

[sv/multitouch_contact_slot_tracker.sv]
// Contact slot tracker: slot table in a synchronous memory, sequencer and registered
// output word. Depends on mcst_pkg.
`timescale 1ns / 1ps
//
//  channel   direction  tdata                                  tuser         tlast
//  s_        in         finger_id, is_down, pos_x_in, pos_y_in  req_type      -
//  m_        out        slot report fields                     report_kind   last
//
// A contact event scans the slots from the cursor, one memory read a cycle; a tick reads,
// reports and writes back one slot a cycle while the output is free; a clear sends a
// single clear report. The single memory read port paces the scan and the tick.
// Reset and clear empty the table at once through per-slot valid bits.
// A stalled output holds the sequencer; a new word is taken while a result waits.

module multitouch_contact_slot_tracker
    import mcst_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // finger_id, is_down, pos_x_in, pos_y_in, zero fill
    input  logic [S_DATA_W-1:0] s_tdata,
    // req_type
    input  logic [1:0]          s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // slot_index, event_status, touch_number, pos_x, pos_y, delta_x, delta_y,
    // slot_phase, release_edge, zero fill
    output logic [M_DATA_W-1:0] m_tdata,
    // report_kind
    output logic [1:0]          m_tuser,
    output logic                m_tlast
);

    slot_t                  slot_mem [SLOT_COUNT];
    slot_t                  mem_rdata_reg;
    logic [SLOT_BITS-1:0]   rd_addr_reg;

    logic                   mem_we;
    logic                   mem_re;
    logic [SLOT_BITS-1:0]   mem_wr_addr;
    logic [SLOT_BITS-1:0]   mem_rd_addr;
    slot_t                  mem_wr_data;

    state_t                 state_reg, state_next;
    logic [SLOT_COUNT-1:0]  vld_reg, vld_next;
    logic [SLOT_BITS-1:0]   cursor_reg, cursor_next;
    logic [ID_BITS-1:0]     number_reg, number_next;
    logic                   m_tvalid_reg, m_tvalid_next;

    logic [M_DATA_W-1:0]    m_tdata_reg, m_tdata_next;
    logic [1:0]             m_tuser_reg, m_tuser_next;
    logic                   m_tlast_reg, m_tlast_next;
    logic [CNT_BITS-1:0]    cnt_reg, cnt_next;
    logic                   free_vld_reg, free_vld_next;
    logic [SLOT_BITS-1:0]   free_slot_reg, free_slot_next;
    slot_t                  ent_reg, ent_next;
    logic [SLOT_BITS-1:0]   ev_slot_reg, ev_slot_next;
    status_t                ev_status_reg, ev_status_next;
    logic                   ev_wr_reg, ev_wr_next;
    logic [ID_BITS-1:0]     fid_reg, fid_next;
    logic                   down_reg, down_next;
    logic signed [COORD_BITS-1:0] x_reg, x_next;
    logic signed [COORD_BITS-1:0] y_reg, y_next;

    logic                   s_accept;
    logic                   out_free;
    slot_t                  cur_ent;
    logic                   cur_match;
    logic                   cur_free;
    logic                   scan_last;
    logic                   tick_last;
    logic [CNT_BITS-1:0]    addr_sum;
    logic [SLOT_BITS-1:0]   scan_addr;
    logic [ID_BITS-1:0]     number_inc;
    logic [ID_BITS-1:0]     in_fid;

    assign s_tready  = (state_reg == S_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign in_fid    = s_tdata[S_FID_LSB +: ID_BITS];

    assign cur_ent   = vld_reg[rd_addr_reg] ? mem_rdata_reg : SLOT_RESET;
    assign cur_match = (cur_ent.finger == fid_reg);
    assign cur_free  = (cur_ent.finger == '0);
    assign scan_last = (cnt_reg == CNT_BITS'(SLOT_COUNT));
    assign tick_last = (rd_addr_reg == SLOT_BITS'(SLOT_COUNT - 1));

    assign addr_sum  = {1'b0, cursor_reg} + cnt_reg;
    assign scan_addr = (addr_sum >= CNT_BITS'(SLOT_COUNT))
                     ? SLOT_BITS'(addr_sum - CNT_BITS'(SLOT_COUNT))
                     : SLOT_BITS'(addr_sum);
    assign number_inc = number_reg + 1'b1;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            slot_mem[mem_wr_addr] <= mem_wr_data;
        end
        if (mem_re) begin
            mem_rdata_reg <= slot_mem[mem_rd_addr];
            rd_addr_reg   <= mem_rd_addr;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    case (s_tuser)
                        REQ_EVENT: state_next = (in_fid == '0) ? S_EVT_OUT : S_SCAN;
                        REQ_TICK:  state_next = S_TICK;
                        REQ_CLEAR: state_next = S_CLEAR_OUT;
                        default:   state_next = S_IDLE;
                    endcase
                end
            end
            S_SCAN: begin
                if (cur_match || scan_last) begin
                    state_next = S_EVT_OUT;
                end
            end
            S_EVT_OUT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            S_TICK: begin
                if (out_free && tick_last) begin
                    state_next = S_IDLE;
                end
            end
            S_CLEAR_OUT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_wr_addr    = ev_slot_reg;
        mem_rd_addr    = scan_addr;
        mem_wr_data    = ent_reg;
        vld_next       = vld_reg;
        cursor_next    = cursor_reg;
        number_next    = number_reg;
        m_tdata_next   = m_tdata_reg;
        m_tuser_next   = m_tuser_reg;
        m_tlast_next   = m_tlast_reg;
        m_tvalid_next  = m_tready ? 1'b0 : m_tvalid_reg;
        cnt_next       = cnt_reg;
        free_vld_next  = free_vld_reg;
        free_slot_next = free_slot_reg;
        ent_next       = ent_reg;
        ev_slot_next   = ev_slot_reg;
        ev_status_next = ev_status_reg;
        ev_wr_next     = ev_wr_reg;
        fid_next       = fid_reg;
        down_next      = down_reg;
        x_next         = x_reg;
        y_next         = y_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    fid_next       = in_fid;
                    down_next      = s_tdata[S_DOWN_LSB];
                    x_next         = s_tdata[S_X_LSB +: COORD_BITS];
                    y_next         = s_tdata[S_Y_LSB +: COORD_BITS];
                    free_vld_next  = 1'b0;
                    ev_wr_next     = 1'b0;
                    ev_status_next = EV_DROPPED;
                    case (s_tuser)
                        REQ_EVENT: begin
                            if (in_fid != '0) begin
                                mem_re      = 1'b1;
                                mem_rd_addr = cursor_reg;
                                cnt_next    = CNT_BITS'(1);
                            end
                        end
                        REQ_TICK: begin
                            mem_re      = 1'b1;
                            mem_rd_addr = '0;
                        end
                        REQ_CLEAR: begin
                            vld_next = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (!scan_last) begin
                    mem_re   = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                end
                if (!free_vld_reg && cur_free) begin
                    free_vld_next  = 1'b1;
                    free_slot_next = rd_addr_reg;
                end
                if (cur_match) begin
                    ent_next     = cur_ent;
                    ev_slot_next = rd_addr_reg;
                    ev_wr_next   = 1'b1;
                    if (down_reg) begin
                        ent_next.cur_x = x_reg;
                        ent_next.cur_y = y_reg;
                        ev_status_next = EV_MOVED;
                    end else begin
                        ent_next.phase = PH_UP;
                        ev_status_next = EV_RELEASED;
                    end
                end else if (scan_last && down_reg && (free_vld_reg || cur_free)) begin
                    ev_slot_next   = free_vld_reg ? free_slot_reg : rd_addr_reg;
                    ev_wr_next     = 1'b1;
                    ev_status_next = EV_CLAIMED;
                    ent_next       = '{
                        finger: fid_reg, touch: number_reg, phase: PH_JUST,
                        cur_x: x_reg, cur_y: y_reg, prev_x: x_reg, prev_y: y_reg
                    };
                    cursor_next = (cursor_reg == SLOT_BITS'(SLOT_COUNT - 1))
                                ? '0 : cursor_reg + 1'b1;
                    number_next = (number_inc == '0) ? ID_BITS'(1) : number_inc;
                end
            end
            S_EVT_OUT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = KIND_EVENT;
                    m_tlast_next  = 1'b1;
                    if (ev_wr_reg) begin
                        m_tdata_next          = make_report(ev_slot_reg, ev_status_reg, ent_reg);
                        mem_we                = 1'b1;
                        vld_next[ev_slot_reg] = 1'b1;
                    end else begin
                        m_tdata_next                     = '0;
                        m_tdata_next[M_STATUS_LSB +: 2]  = EV_DROPPED;
                    end
                end
            end
            S_TICK: begin
                if (out_free) begin
                    m_tvalid_next         = 1'b1;
                    m_tuser_next          = KIND_SLOT;
                    m_tlast_next          = tick_last;
                    m_tdata_next          = make_report(rd_addr_reg, EV_MOVED, cur_ent);
                    mem_we                = 1'b1;
                    mem_wr_addr           = rd_addr_reg;
                    mem_wr_data           = tick_update(cur_ent);
                    vld_next[rd_addr_reg] = 1'b1;
                    if (!tick_last) begin
                        mem_re      = 1'b1;
                        mem_rd_addr = rd_addr_reg + 1'b1;
                    end
                end
            end
            S_CLEAR_OUT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = KIND_CLEAR;
                    m_tlast_next  = 1'b1;
                    m_tdata_next  = '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            vld_reg      <= '0;
            cursor_reg   <= '0;
            number_reg   <= ID_BITS'(1);
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            vld_reg      <= vld_next;
            cursor_reg   <= cursor_next;
            number_reg   <= number_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg   <= m_tdata_next;
        m_tuser_reg   <= m_tuser_next;
        m_tlast_reg   <= m_tlast_next;
        cnt_reg       <= cnt_next;
        free_vld_reg  <= free_vld_next;
        free_slot_reg <= free_slot_next;
        ent_reg       <= ent_next;
        ev_slot_reg   <= ev_slot_next;
        ev_status_reg <= ev_status_next;
        ev_wr_reg     <= ev_wr_next;
        fid_reg       <= fid_next;
        down_reg      <= down_next;
        x_reg         <= x_next;
        y_reg         <= y_next;
    end

endmodule
